// File: rtl/fc_pkg.sv
package fc_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int PROD_W      = 2 * VALUE_WIDTH;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int IN_DATA_W   = ((4 * VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        value_t quot;
        value_t rem;
    } div_rsp_t;

    function automatic value_t magnitude(input value_t v);
        value_t m;
        m = v[VALUE_WIDTH-1] ? (~v + value_t'(1)) : v;
        return m;
    endfunction

endpackage

// File: rtl/fc_divider.sv
module fc_divider
    import fc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    value_t           rem_reg;
    value_t           rem_next;
    value_t           quot_reg;
    value_t           quot_next;
    value_t           divisor_reg;
    value_t           divisor_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH+1:0] diff;
    logic                   take;

    // one restoring step per cycle, quotient bits shift in from the bottom
    assign shifted = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};
    assign take    = ~diff[VALUE_WIDTH+1];

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(VALUE_WIDTH - 1);
            rem_next     = '0;
            quot_next    = req.dividend;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            quot_next = {quot_reg[VALUE_WIDTH-2:0], take};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: rtl/fraction_compare.sv
// channel  dir  signals                     beat
// s        in   s_tvalid s_tready s_tdata   num_a, den_a, num_b, den_b
// m        out  m_tvalid m_tready m_tdata   is_equal, is_less, zero_denominator
//
// one shared restoring divider for the euclid steps and both scale factors
// a zero denominator skips all arithmetic, result valid the cycle after the beat
// s_tready is high only while idle; result held in m_tdata until m_tready
// asynchronous active-low reset clears the sequencer and the output valid
module fraction_compare
    import fc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // num_a, den_a, num_b, den_b
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // is_equal, is_less, zero_denominator
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_START,
        S_GCD_WAIT,
        S_FA_START,
        S_FA_WAIT,
        S_FB_START,
        S_FB_WAIT,
        S_MUL_A,
        S_MUL_B,
        S_CMP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    value_t mna_reg, mna_next;
    value_t mnb_reg, mnb_next;
    logic   neg_a_reg, neg_a_next;
    logic   neg_b_reg, neg_b_next;
    value_t ma_reg, ma_next;
    value_t mb_reg, mb_next;
    value_t ga_reg, ga_next;
    value_t gb_reg, gb_next;
    value_t fa_reg, fa_next;
    value_t fb_reg, fb_next;
    logic signed [PROD_W-1:0] sa_reg, sa_next;
    logic signed [PROD_W-1:0] sb_reg, sb_next;
    logic [2:0] res_reg, res_next;

    value_t in_na, in_da, in_nb, in_db;
    logic   accept;

    div_req_t div_req;
    div_rsp_t div_rsp;

    value_t                   mul_x;
    value_t                   mul_y;
    logic                     mul_neg;
    logic [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0] scaled;

    assign in_na = s_tdata[VALUE_WIDTH-1:0];
    assign in_da = s_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    assign in_nb = s_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH];
    assign in_db = s_tdata[4*VALUE_WIDTH-1:3*VALUE_WIDTH];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    fc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = ga_reg;
        div_req.divisor  = gb_reg;
        case (state_reg)
            S_GCD_START:
            begin
                div_req.start = (gb_reg != '0);
            end
            S_FA_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mb_reg;
                div_req.divisor  = ga_reg;
            end
            S_FB_START:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ma_reg;
                div_req.divisor  = ga_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // single multiplier shared by both scaled numerators
    assign mul_x   = (state_reg == S_MUL_A) ? mna_reg : mnb_reg;
    assign mul_y   = (state_reg == S_MUL_A) ? fa_reg : fb_reg;
    assign mul_neg = (state_reg == S_MUL_A) ? neg_a_reg : neg_b_reg;
    assign prod    = {{VALUE_WIDTH{1'b0}}, mul_x} * {{VALUE_WIDTH{1'b0}}, mul_y};
    assign scaled  = mul_neg ? -$signed(prod) : $signed(prod);

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        mna_next      = mna_reg;
        mnb_next      = mnb_reg;
        neg_a_next    = neg_a_reg;
        neg_b_next    = neg_b_reg;
        ma_next       = ma_reg;
        mb_next       = mb_reg;
        ga_next       = ga_reg;
        gb_next       = gb_reg;
        fa_next       = fa_reg;
        fb_next       = fb_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        res_next      = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mna_next   = magnitude(in_na);
                    mnb_next   = magnitude(in_nb);
                    neg_a_next = in_na[VALUE_WIDTH-1] ^ in_da[VALUE_WIDTH-1];
                    neg_b_next = in_nb[VALUE_WIDTH-1] ^ in_db[VALUE_WIDTH-1];
                    ma_next    = magnitude(in_da);
                    mb_next    = magnitude(in_db);
                    ga_next    = magnitude(in_da);
                    gb_next    = magnitude(in_db);
                    if ((in_da == '0) || (in_db == '0))
                    begin
                        res_next      = 3'b100;
                        m_tvalid_next = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_GCD_START;
                    end
                end
            end
            S_GCD_START:
            begin
                state_next = (gb_reg == '0) ? S_FA_START : S_GCD_WAIT;
            end
            S_GCD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = div_rsp.rem;
                    state_next = S_GCD_START;
                end
            end
            S_FA_START:
            begin
                state_next = S_FA_WAIT;
            end
            S_FA_WAIT:
            begin
                if (div_rsp.done)
                begin
                    fa_next    = div_rsp.quot;
                    state_next = S_FB_START;
                end
            end
            S_FB_START:
            begin
                state_next = S_FB_WAIT;
            end
            S_FB_WAIT:
            begin
                if (div_rsp.done)
                begin
                    fb_next    = div_rsp.quot;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                sa_next    = scaled;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                sb_next    = scaled;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                res_next      = {1'b0, (sa_reg < sb_reg), (sa_reg == sb_reg)};
                m_tvalid_next = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mna_reg   <= mna_next;
        mnb_reg   <= mnb_next;
        neg_a_reg <= neg_a_next;
        neg_b_reg <= neg_b_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        fa_reg    <= fa_next;
        fb_reg    <= fb_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 3){1'b0}}, res_reg};

endmodule

// File: dv/fraction_compare_checker.sv
module fraction_compare_checker
    import fc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    mismatch_count,
    output int                    verdicts_due
);

    typedef logic signed [VALUE_WIDTH-1:0] sval_t;

    // highest bit first, as in m_tdata
    typedef struct packed {
        logic zero_denominator;
        logic is_less;
        logic is_equal;
    } verdict_t;

    verdict_t due_verdicts[$];
    verdict_t want;
    verdict_t got;

    function automatic verdict_t compare_fractions(input sval_t na, input sval_t da,
                                                   input sval_t nb, input sval_t db);
        verdict_t v;
        longint   ma;
        longint   mb;
        longint   x;
        longint   y;
        longint   r;
        longint   sa;
        longint   sb;
        v = '0;
        if (da == 0 || db == 0)
        begin
            v.zero_denominator = 1'b1;
            return v;
        end
        ma = (da < 0) ? -longint'(da) : longint'(da);
        mb = (db < 0) ? -longint'(db) : longint'(db);
        x = ma;
        y = mb;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        // the scaled numerator carries the sign of its own denominator
        sa = longint'(na) * (mb / x);
        if (da < 0)
            sa = -sa;
        sb = longint'(nb) * (ma / x);
        if (db < 0)
            sb = -sb;
        v.is_equal = (sa == sb);
        v.is_less  = (sa < sb);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_verdicts.delete();
            mismatch_count <= 0;
            verdicts_due   <= 0;
        end
        else
        begin
            // results never leave in the cycle their beat arrives, so pop first
            if (m_tvalid && m_tready)
            begin
                got = verdict_t'(m_tdata[2:0]);
                if (due_verdicts.size() == 0)
                begin
                    $display("%0t: result with none due, got eq=%b lt=%b zd=%b",
                             $realtime, got.is_equal, got.is_less, got.zero_denominator);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (got.is_equal !== want.is_equal || got.is_less !== want.is_less
                        || got.zero_denominator !== want.zero_denominator)
                    begin
                        $display("%0t: expected eq=%b lt=%b zd=%b, got eq=%b lt=%b zd=%b",
                                 $realtime, want.is_equal, want.is_less,
                                 want.zero_denominator, got.is_equal, got.is_less,
                                 got.zero_denominator);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_verdicts.push_back(compare_fractions(s_tdata[0 +: VALUE_WIDTH],
                                                         s_tdata[VALUE_WIDTH +: VALUE_WIDTH],
                                                         s_tdata[2*VALUE_WIDTH +: VALUE_WIDTH],
                                                         s_tdata[3*VALUE_WIDTH +: VALUE_WIDTH]));
            verdicts_due <= due_verdicts.size();
        end
    end

endmodule

// File: dv/fraction_compare_tb.sv
module fraction_compare_tb;
    import fc_pkg::*;

    localparam int RANDOM_ITEMS   = 1500;
    localparam int QUIET_TAIL     = 150;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int VMAX           = (1 << (VALUE_WIDTH - 1)) - 1;
    localparam int VMIN           = -(1 << (VALUE_WIDTH - 1));

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatch_count;
    int verdicts_due;
    int idle_cycles;
    bit quiet;
    bit long_hold_req;

    fraction_compare dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fraction_compare_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .verdicts_due   (verdicts_due)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("fraction_compare_tb: done, errors");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_fractions(input int na, input int da,
                                                            input int nb, input int db);
        logic [IN_DATA_W-1:0] beat;
        beat = '0;
        beat[0 +: VALUE_WIDTH]             = na[VALUE_WIDTH-1:0];
        beat[VALUE_WIDTH +: VALUE_WIDTH]   = da[VALUE_WIDTH-1:0];
        beat[2*VALUE_WIDTH +: VALUE_WIDTH] = nb[VALUE_WIDTH-1:0];
        beat[3*VALUE_WIDTH +: VALUE_WIDTH] = db[VALUE_WIDTH-1:0];
        return beat;
    endfunction

    function automatic int pick_range(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int pick_edge_value();
        case ($urandom_range(0, 6))
            0: return VMIN;
            1: return VMIN + 1;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return VMAX;
            default: return pick_range(VMIN, VMAX);
        endcase
    endfunction

    function automatic int pick_nonzero(input int lim);
        int v;
        v = pick_range(1, lim);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_fractions();
        int na;
        int da;
        int nb;
        int db;
        int k;
        int f;
        na = pick_range(VMIN, VMAX);
        da = pick_range(VMIN, VMAX);
        nb = pick_range(VMIN, VMAX);
        db = pick_range(VMIN, VMAX);
        case ($urandom_range(0, 9))
            2, 3:
            begin
                // the same fraction written two ways, at times with nb moved by up to one
                na = pick_range(-180, 180);
                da = pick_nonzero(180);
                k  = pick_nonzero(180);
                nb = na * k;
                db = da * k;
                if ($urandom_range(0, 3) == 0)
                    nb = nb + pick_range(-1, 1);
            end
            4:
            begin
                na = pick_range(-8, 8);
                da = pick_range(-8, 8);
                nb = pick_range(-8, 8);
                db = pick_range(-8, 8);
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0: da = 0;
                    1: db = 0;
                    default:
                    begin
                        da = 0;
                        db = 0;
                    end
                endcase
            end
            6:
            begin
                // denominators sharing a large factor
                f  = pick_range(2, 2000);
                da = f * pick_nonzero(VMAX / f);
                db = f * pick_nonzero(VMAX / f);
            end
            7:
            begin
                na = pick_edge_value();
                da = pick_edge_value();
                nb = pick_edge_value();
                db = pick_edge_value();
            end
            8:
            begin
                nb = $urandom_range(0, 1) ? na : na + pick_range(-2, 2);
                db = $urandom_range(0, 1) ? da : -da;
            end
            default:
            begin
            end
        endcase
        return pack_fractions(na, da, nb, db);
    endfunction

    task automatic send_fractions(input logic [IN_DATA_W-1:0] beat);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts_due != 0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fractions(pack_fractions(1, 2, 2, 4));
        send_fractions(pack_fractions(1, 3, 1, 2));
        send_fractions(pack_fractions(2, 4, 1, 2));
        send_fractions(pack_fractions(VMIN, VMAX, VMAX, VMIN));
        send_fractions(pack_fractions(VMIN, VMIN, VMAX, VMAX));
        send_fractions(pack_fractions(VMAX, VMAX, VMIN, VMIN));
        send_fractions(pack_fractions(0, 5, 0, -7));
        send_fractions(pack_fractions(5, 0, 1, 1));
        send_fractions(pack_fractions(1, 1, 3, 0));
        send_fractions(pack_fractions(0, 0, 0, 0));
        send_fractions(pack_fractions(VMIN, 0, VMAX, VMIN));
        send_fractions(pack_fractions(3, -4, 3, 4));
        send_fractions(pack_fractions(-1, -1, 1, 1));
        // consecutive fibonacci denominators give a long remainder chain
        send_fractions(pack_fractions(28657, 17711, 17711, 10946));
        send_fractions(pack_fractions(VMAX, -1, VMIN, 1));
        send_fractions(pack_fractions(7, VMAX, 7, VMIN));
        send_fractions(pack_fractions(VMIN, -1, VMIN, 1));
        send_fractions(pack_fractions(12345, 6, 12345, 9));
        send_fractions(pack_fractions(-5, 7, -5, 7));
        send_fractions(pack_fractions(1, VMIN, -1, VMAX));
        send_fractions(pack_fractions(-1, 1, 1, -1));
        send_fractions(pack_fractions(-1, -32767, -1, -32767));
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
                long_hold_req = 1'b1;
            if (i == (2 * RANDOM_ITEMS) / 3)
                drain_results();
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            send_fractions(random_fractions());
        end
        drain_results();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && verdicts_due == 0)
            $display("fraction_compare_tb: done, clean");
        else
            $display("fraction_compare_tb: done, errors");
        $finish;
    end

endmodule
